// ----- hdl/jfe_pkg.sv -----
package jfe_pkg;

    // Transfer block length and the width of the fill counter
    localparam int BLOCK_BYTES = 512;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);
    localparam int RUN_MAX     = 3;
    localparam int RUN_W       = $clog2(RUN_MAX + 1);

    // Marker bytes
    localparam logic [7:0] MARK_FF  = 8'hFF;
    localparam logic [7:0] MARK_SOI = 8'hD8;
    localparam logic [7:0] MARK_EOI = 8'hD9;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_IMAGE  = 2'd1,
        MODE_AFTER  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       block_end;
        logic       run_last;
    } t_out_beat;

    // Core status seen by the top level checks
    typedef struct packed {
        t_mode            mode;
        logic [RUN_W-1:0] left;
    } t_core_status;

endpackage

// ----- hdl/jfe_core.sv -----
module jfe_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  jfe_pkg::t_in_beat    i_in_beat,
    output logic                 o_head_valid,
    output jfe_pkg::t_out_beat   o_head,
    input  logic                 i_head_take,
    output jfe_pkg::t_core_status o_status
);
    import jfe_pkg::*;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);

    t_mode             r_mode, n_mode;
    logic [7:0]        r_prev, n_prev;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [RUN_W-1:0]  r_left;
    t_out_beat         r_run [0:RUN_MAX-1];

    t_out_beat         gen [0:RUN_MAX-1];
    logic [RUN_W-1:0]  gen_n;
    logic              after_ff;
    logic              blk_end;
    logic              pop;
    logic              in_acc;

    // Handshake: a new byte loads when the run buffer is empty or empties this cycle
    assign pop        = (r_left != '0) && i_head_take;
    assign o_in_stall = !((r_left == '0) || ((r_left == RUN_W'(1)) && pop));
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_head_valid = (r_left != '0);
    assign o_head       = r_run[0];
    assign o_status     = '{mode: r_mode, left: r_left};

    assign after_ff = (r_prev == MARK_FF);
    assign blk_end  = i_in_beat.final_byte || (r_fill == FILL_LAST);

    // Per-byte decode: next state and the run of beats it causes
    always_comb begin
        n_mode = r_mode;
        n_prev = r_prev;
        n_fill = r_fill;
        gen_n  = '0;
        for (int k = 0; k < RUN_MAX; k++) begin
            gen[k] = '0;
        end
        unique case (r_mode)
            MODE_IMAGE: begin
                if (after_ff && i_in_beat.data_byte == MARK_EOI) begin
                    gen[0] = '{out_byte: i_in_beat.data_byte, block_end: 1'b1,
                               run_last: 1'b1};
                    gen_n  = RUN_W'(1);
                    n_fill = '0;
                    n_mode = MODE_AFTER;
                end else begin
                    gen[0] = '{out_byte: i_in_beat.data_byte, block_end: blk_end,
                               run_last: !i_in_beat.final_byte};
                    n_fill = blk_end ? '0 : r_fill + FILL_W'(1);
                    if (i_in_beat.final_byte) begin
                        gen[1] = '{out_byte: MARK_FF, block_end: 1'b0, run_last: 1'b0};
                        gen[2] = '{out_byte: MARK_EOI, block_end: 1'b1, run_last: 1'b1};
                        gen_n  = RUN_W'(3);
                    end else begin
                        gen_n  = RUN_W'(1);
                    end
                end
            end
            MODE_AFTER: begin
                gen[0] = '{out_byte: 8'h00, block_end: blk_end, run_last: 1'b1};
                gen_n  = RUN_W'(1);
                n_fill = blk_end ? '0 : r_fill + FILL_W'(1);
            end
            default: begin
                // searching; only FF D8 opens an image
                if (after_ff && i_in_beat.data_byte == MARK_SOI
                        && !i_in_beat.final_byte) begin
                    gen[0] = '{out_byte: MARK_FF, block_end: 1'b0, run_last: 1'b0};
                    gen[1] = '{out_byte: MARK_SOI, block_end: 1'b1, run_last: 1'b1};
                    gen_n  = RUN_W'(2);
                    n_mode = MODE_IMAGE;
                    n_fill = '0;
                end
            end
        endcase
        // end of capture returns to the reset state
        if (i_in_beat.final_byte) begin
            n_mode = MODE_SEARCH;
            n_prev = '0;
            n_fill = '0;
        end else begin
            n_prev = i_in_beat.data_byte;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SEARCH;
            r_prev <= '0;
            r_fill <= '0;
            r_left <= '0;
        end else begin
            if (in_acc) begin
                r_mode <= n_mode;
                r_prev <= n_prev;
                r_fill <= n_fill;
                r_left <= gen_n;
            end else if (pop) begin
                r_left <= r_left - RUN_W'(1);
            end
        end
    end

    // Run buffer payload, drained from entry 0
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < RUN_MAX; k++) begin
                r_run[k] <= gen[k];
            end
        end else if (pop) begin
            for (int k = 0; k < RUN_MAX - 1; k++) begin
                r_run[k] <= r_run[k + 1];
            end
        end
    end

endmodule

// ----- hdl/jfe_out.sv -----
module jfe_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  jfe_pkg::t_out_beat i_head,
    output logic               o_head_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jfe_pkg::t_out_beat o_out_beat
);
    import jfe_pkg::*;

    logic      r_valid;
    t_out_beat r_beat;

    // Register takes a beat when empty or when its beat leaves
    assign o_head_take = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_head_take) begin
            r_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_head_take) begin
            r_beat <= i_head;
        end
    end

endmodule

// ----- hdl/jpeg_frame_extractor.sv -----
// Channel   Valid        Stall        Beat
// input     i_in_valid   o_in_stall   i_in_beat  (data_byte, final_byte)
// output    o_out_valid  i_out_stall  o_out_beat (out_byte, block_end, run_last)
//
// One byte per cycle while the output does not stall and each byte yields zero
// or one beat. A byte yielding two (start marker) or three (stream end inside an
// image) beats holds the input while the three-entry run buffer drains one beat
// a cycle, unless the output stalls, into the registered output stage after it.
// Synchronous active-low reset empties both stages and restarts the search.
// A stalled output beat holds; bytes are still taken until a run is pending.
module jpeg_frame_extractor (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  jfe_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output jfe_pkg::t_out_beat o_out_beat
);
    import jfe_pkg::*;

    logic         head_valid;
    t_out_beat    head;
    logic         head_take;
    t_core_status status;

    jfe_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_take  (head_take),
        .o_status     (status)
    );

    jfe_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_take  (head_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_beat   (o_out_beat)
    );

    // A final byte always sends the extractor back to searching
    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_beat.final_byte
        |=> status.mode == MODE_SEARCH)
        else $error("final byte did not restart the search");

    // Input only stalls while a run is pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> status.left != '0)
        else $error("input stalled with an empty run buffer");

    // Reset leaves both stages empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && status.left == '0)
        else $error("stages not empty after reset");

    // A beat marked last of its run cannot be followed by a pending tail
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head_valid && head.run_last |-> status.left == RUN_W'(1))
        else $error("run_last beat with more beats behind it");

endmodule

// ----- sim/jpeg_frame_extractor_tb.sv -----
`timescale 1ns / 100ps

module jpeg_frame_extractor_tb;
    import jfe_pkg::*;

    // Idle schemes, one per phase
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int PHASE_ITEMS = 100;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_in_beat   i_in_beat   = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_out_beat  o_out_beat;

    jpeg_frame_extractor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

    // Bytes waiting to be sent, and stream beats the extractor owes us
    t_in_beat  fifo_bytes_q[$];
    t_out_beat stream_exp_q[$];

    // Shadow copy of the extractor state
    t_mode       sh_mode = MODE_SEARCH;
    logic [7:0]  sh_prev = 8'h00;
    logic [12:0] sh_fill = 13'd0;

    int idle_scheme  = IDLE_NONE;
    int cyc          = 0;
    int n_errors     = 0;
    int n_queued     = 0;
    int n_bytes_in   = 0;
    int n_beats_out  = 0;
    int n_block_ends = 0;
    int n_images     = 0;
    int n_truncated  = 0;

    // Clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) cyc <= cyc + 1;

    // Idling is off during the quiet stretch at the start of each period
    function automatic bit quiet_stretch();
        return (cyc % 200) < 40;
    endfunction

    function automatic bit sender_idles();
        if (quiet_stretch()) return 1'b0;
        case (idle_scheme)
            IDLE_SEND: return $urandom_range(99) < 70;
            IDLE_BOTH: return $urandom_range(99) < 7;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        if (quiet_stretch()) return 1'b0;
        case (idle_scheme)
            IDLE_RECV: return $urandom_range(99) < 70;
            IDLE_BOTH: return $urandom_range(99) < 7;
            default:   return 1'b0;
        endcase
    endfunction

    // Advance the block fill count; 1 when this byte closes a block
    function automatic logic bump_fill(input logic fin);
        sh_fill = sh_fill + 13'd1;
        if (sh_fill >= BLOCK_BYTES || fin) begin
            sh_fill = 13'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out the stream beats caused by one accepted FIFO byte
    task automatic predict_stream(input t_in_beat b);
        t_out_beat run [3];
        int        n;
        logic      after_ff;
        n        = 0;
        after_ff = (sh_prev == MARK_FF);
        case (sh_mode)
            MODE_IMAGE: begin
                if (after_ff && b.data_byte == MARK_EOI) begin
                    run[n++] = '{b.data_byte, 1'b1, 1'b0};
                    sh_fill  = 13'd0;
                    sh_mode  = MODE_AFTER;
                end else begin
                    run[n++] = '{b.data_byte, bump_fill(b.final_byte), 1'b0};
                    // stream cut inside an image: close it with an end marker
                    if (b.final_byte) begin
                        run[n++] = '{MARK_FF, 1'b0, 1'b0};
                        run[n++] = '{MARK_EOI, 1'b1, 1'b0};
                        n_truncated++;
                    end
                end
            end
            MODE_AFTER: begin
                run[n++] = '{8'h00, bump_fill(b.final_byte), 1'b0};
            end
            default: begin
                // only FF D8 starts an image, and not on the final byte
                if (after_ff && b.data_byte == MARK_SOI && !b.final_byte) begin
                    run[n++] = '{MARK_FF, 1'b0, 1'b0};
                    run[n++] = '{MARK_SOI, 1'b1, 1'b0};
                    sh_mode  = MODE_IMAGE;
                    sh_fill  = 13'd0;
                    n_images++;
                end
            end
        endcase
        if (n > 0) run[n-1].run_last = 1'b1;
        for (int k = 0; k < n; k++) stream_exp_q.push_back(run[k]);
        if (b.final_byte) begin
            sh_mode = MODE_SEARCH;
            sh_prev = 8'h00;
            sh_fill = 13'd0;
        end else begin
            sh_prev = b.data_byte;
        end
    endtask

    // Driver: present queued bytes, predict on each accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_stream(i_in_beat);
                n_bytes_in++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (fifo_bytes_q.size() != 0 && !sender_idles()) begin
                    i_in_beat  <= fifo_bytes_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on beat %0d: %s got %0h expected %0h",
                 $realtime, n_beats_out, what, got, want);
        n_errors++;
    endtask

    // Monitor: check each accepted output beat, drive random stall
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (stream_exp_q.size() == 0) begin
                    report_mismatch("unexpected beat, out_byte", o_out_beat.out_byte, 0);
                end else begin
                    want = stream_exp_q.pop_front();
                    if (o_out_beat.out_byte !== want.out_byte)
                        report_mismatch("out_byte", o_out_beat.out_byte, want.out_byte);
                    if (o_out_beat.block_end !== want.block_end)
                        report_mismatch("block_end", o_out_beat.block_end, want.block_end);
                    if (o_out_beat.run_last !== want.run_last)
                        report_mismatch("run_last", o_out_beat.run_last, want.run_last);
                end
                if (o_out_beat.block_end === 1'b1) n_block_ends++;
                n_beats_out++;
            end
            i_out_stall <= receiver_stalls();
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic fin);
        t_in_beat b;
        b.data_byte  = d;
        b.final_byte = fin;
        fifo_bytes_q.push_back(b);
        n_queued++;
    endtask

    // Random byte biased toward the marker values
    function automatic logic [7:0] marker_heavy_byte();
        int r;
        r = $urandom_range(15);
        if (r < 4)   return MARK_FF;
        if (r == 4)  return MARK_SOI;
        if (r == 5)  return MARK_EOI;
        if (r == 6)  return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // One capture: mostly images, half of them cut short, some noise and broken starts
    task automatic add_capture(input int body_max);
        int kind;
        int n;
        kind = $urandom_range(9);
        if (kind < 6) begin
            n = $urandom_range(3);
            repeat (n) push_byte(marker_heavy_byte(), 1'b0);
            push_byte(MARK_FF, 1'b0);
            push_byte(MARK_SOI, 1'b0);
            n = $urandom_range(body_max);
            repeat (n) push_byte(marker_heavy_byte(), 1'b0);
            if ($urandom_range(1)) begin
                push_byte(MARK_FF, 1'b0);
                push_byte(MARK_EOI, 1'b0);
                n = $urandom_range(5);
                repeat (n) push_byte(marker_heavy_byte(), 1'b0);
            end
            push_byte(marker_heavy_byte(), 1'b1);
        end else if (kind < 8) begin
            n = $urandom_range(8, 1);
            repeat (n - 1) push_byte(marker_heavy_byte(), 1'b0);
            push_byte(marker_heavy_byte(), 1'b1);
        end else begin
            case ($urandom_range(2))
                0: begin
                    push_byte(MARK_FF, 1'b0);
                    push_byte(MARK_SOI, 1'b1);
                end
                1: begin
                    push_byte(MARK_FF, 1'b0);
                    push_byte(MARK_SOI, 1'b0);
                    push_byte(MARK_FF, 1'b1);
                end
                default: begin
                    push_byte(MARK_FF, 1'b0);
                    push_byte(MARK_EOI, 1'b0);
                    push_byte(MARK_SOI, 1'b1);
                end
            endcase
        end
    endtask

    task automatic directed_captures();
        // noise, an ignored end marker, a start, an inner FF D8, an end, padding
        push_byte(8'h12, 1'b0);
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_EOI, 1'b0);
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_SOI, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_SOI, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_EOI, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'hAA, 1'b1);
        // start marker on the final byte is dropped
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_SOI, 1'b1);
        // stream ends inside an image on an FF
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_SOI, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(MARK_FF, 1'b1);
        // final byte clears the previous byte: no start across captures
        push_byte(MARK_FF, 1'b1);
        push_byte(MARK_SOI, 1'b1);
        // end marker on the final byte
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_SOI, 1'b0);
        push_byte(MARK_FF, 1'b0);
        push_byte(MARK_EOI, 1'b1);
    endtask

    task automatic wait_drained();
        while (fifo_bytes_q.size() != 0 || i_in_valid || stream_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        int start;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = IDLE_NONE; ph <= IDLE_BOTH; ph++) begin
            idle_scheme = ph;
            if (ph == IDLE_NONE) begin
                directed_captures();
            end
            start = n_queued;
            while (n_queued - start < PHASE_ITEMS) add_capture(24);
            wait_drained();
        end
        $display("covered %0d FIFO bytes in %0d images (%0d cut short), under four idle schemes",
                 n_bytes_in, n_images, n_truncated);
        $display("checked %0d stream beats, %0d of them closing a transfer block, %0d errors",
                 n_beats_out, n_block_ends, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/jfe_pkg.sv
hdl/jfe_core.sv
hdl/jfe_out.sv
hdl/jpeg_frame_extractor.sv
sim/jpeg_frame_extractor_tb.sv
